/* hw/rtl/dkbc_pkg.sv */
// ----------------------------------------------------------------------------
// dkbc_pkg
// Shared types and constants for the diagonal Kalman bias calibrator.
// ----------------------------------------------------------------------------
package dkbc_pkg;

  localparam int unsigned NUM_FIELDS = 7;
  localparam int unsigned Z_ACCEL_CH = 2;
  localparam logic [31:0] ONE_Q24 = 32'd16777216;
  localparam logic signed [31:0] GRAVITY_Q16 = 32'sd642908;
  localparam logic [31:0] THRESH_RESET = 32'd1595949;

  localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] altitude;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] accel_x_cal;
    logic signed [31:0] accel_y_cal;
    logic signed [31:0] accel_z_cal;
    logic signed [31:0] gyro_x_cal;
    logic signed [31:0] gyro_y_cal;
    logic signed [31:0] gyro_z_cal;
    logic signed [31:0] altitude_cal;
    logic               converged;
    logic               armed;
  } out_item_t;

  // lane control from the sequencer
  typedef struct packed {
    logic        start;
    logic [31:0] q;
    logic [31:0] r;
  } lane_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* hw/rtl/dkbc_lane.sv */
// ----------------------------------------------------------------------------
// dkbc_lane
// One scalar Kalman channel: restoring divide for the gain, then variance
// and estimate update, with both products formed in the S_VMUL state.
// ----------------------------------------------------------------------------
module dkbc_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dkbc_pkg::lane_ctl_t  ctl,
  input  logic signed [31:0]   z,
  output logic signed [31:0]   est,
  output logic [31:0]          var_p,
  output logic                 done
);
  import dkbc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_VMUL = 5'b00100,
    S_EMUL = 5'b01000,
    S_FIN  = 5'b10000
  } lane_st_t;

  lane_st_t st_r, st_nxt;
  logic signed [31:0] est_r;
  logic [31:0] var_r;
  logic [31:0] p_r;
  logic [32:0] s_r;
  logic [33:0] rem_r;
  logic [24:0] quo_r;
  logic [4:0]  cnt_r;
  logic signed [32:0] d_r;
  logic [57:0] prod_r;
  logic        done_r;

  logic [32:0] p_sum;
  logic [33:0] rem_sh;
  logic [32:0] mag;
  logic [24:0] k_use;
  logic [32:0] m;

  assign p_sum = {1'b0, var_r} + {1'b0, ctl.q};
  // dividend is p << 24: bit 24 is p[0], everything below is zero
  assign rem_sh = {rem_r[32:0], ((cnt_r == 5'd0) ? p_r[0] : 1'b0)};
  assign k_use = (s_r == 33'd0) ? 25'd0 : ((quo_r > 25'(ONE_Q24)) ? 25'(ONE_Q24) : quo_r);
  assign mag = d_r[32] ? 33'(-d_r) : 33'(d_r);
  assign m = 33'((prod_r + 58'd8388608) >> 24);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (ctl.start) st_nxt = S_DIV;
      S_DIV:  if (cnt_r == 5'd24) st_nxt = S_VMUL;
      S_VMUL: st_nxt = S_EMUL;
      S_EMUL: st_nxt = S_FIN;
      S_FIN:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      est_r <= '0;
      var_r <= ONE_Q24;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (ctl.start) begin
          // saturate p + q, form full-width denominator
          p_r <= p_sum[32] ? 32'hFFFFFFFF : p_sum[31:0];
          s_r <= {1'b0, (p_sum[32] ? 32'hFFFFFFFF : p_sum[31:0])} + {1'b0, ctl.r};
          d_r <= 33'(z) - 33'(est_r);
          // preload the dividend bits above bit 24, that is p >> 1
          rem_r <= {3'b000, (p_sum[32] ? 31'h7FFFFFFF : p_sum[31:1])};
          quo_r <= '0;
          cnt_r <= '0;
        end
        S_DIV: begin
          // quotient bit 24-cnt of (p << 24) / s
          if (rem_sh >= {1'b0, s_r}) begin
            rem_r <= rem_sh - {1'b0, s_r};
            quo_r <= {quo_r[23:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[23:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
        end
        S_VMUL: begin
          var_r <= 32'((58'(p_r) * 58'(25'(ONE_Q24) - k_use)) >> 24);
          prod_r <= 58'(mag) * 58'(k_use);
        end
        S_EMUL: begin
          est_r <= sat32(34'(est_r) + (d_r[32] ? -34'(m) : 34'(m)));
          done_r <= 1'b1;
        end
        S_FIN: ;
        default: ;
      endcase
    end
  end

  assign est = est_r;
  assign var_p = var_r;
  assign done = done_r;
endmodule

/* hw/rtl/dkbc_merge.sv */
// ----------------------------------------------------------------------------
// dkbc_merge
// Combine lane results: convergence test, gravity offset, output packing.
// ----------------------------------------------------------------------------
module dkbc_merge #(
  parameter int CHANNELS = 7
) (
  input  logic signed [31:0] est [CHANNELS],
  input  logic [31:0]        var_p [CHANNELS],
  input  logic [31:0]        thresh,
  input  logic               armed_in,
  output dkbc_pkg::out_item_t item
);
  import dkbc_pkg::*;

  logic conv;
  logic signed [31:0] cal [NUM_FIELDS];

  always_comb begin
    conv = 1'b1;
    for (int i = 0; i < CHANNELS; i++)
      if (var_p[i] > thresh) conv = 1'b0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      cal[i] = '0;
      if (i < CHANNELS) begin
        if (i == Z_ACCEL_CH) cal[i] = sat32(34'(est[i]) + 34'(GRAVITY_Q16));
        else cal[i] = est[i];
      end
    end
    item.accel_x_cal = cal[0];
    item.accel_y_cal = cal[1];
    item.accel_z_cal = cal[2];
    item.gyro_x_cal = cal[3];
    item.gyro_y_cal = cal[4];
    item.gyro_z_cal = cal[5];
    item.altitude_cal = cal[6];
    item.converged = conv;
    item.armed = armed_in | conv;
  end
endmodule

/* hw/rtl/diagonal_kalman_bias_calibrator_core.sv */
// ----------------------------------------------------------------------------
// diagonal_kalman_bias_calibrator_core
// Seven parallel scalar Kalman lanes with a merging stage for calibration.
// ----------------------------------------------------------------------------
// Channel  Ports                           Meaning
// in       in_valid/in_ready/in_data       one 7-channel sensor sample item
// out      out_valid/out_ready/out_data    estimates, converged, armed item
// cfg      cfg_we/cfg_index/cfg_wdata      q, r, threshold writes
//
// Each item passes from accept to result through the 25-step restoring
// gain divide in every lane, the variance and estimate update steps, the
// completion flag and the load of the output register.
// All lanes run together; one item is in flight at a time.
// A result waits in the output register; the next item is accepted while
// it waits but its result is held back until the register drains.
// Reset is synchronous: estimates clear, variances return to 1.0.
module diagonal_kalman_bias_calibrator_core #(
  parameter int CHANNELS = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dkbc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dkbc_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);
  import dkbc_pkg::*;

  logic [31:0] q_r, r_r, th_r;
  logic busy_r, pend_r, armed_r, out_valid_r;
  out_item_t out_r, merged;
  lane_ctl_t ctl;
  logic signed [31:0] zin [CHANNELS];
  logic signed [31:0] est [CHANNELS];
  logic [31:0] vp [CHANNELS];
  logic [CHANNELS-1:0] done;
  logic signed [31:0] fld [NUM_FIELDS];
  logic accept;

  assign fld[0] = in_data.accel_x;
  assign fld[1] = in_data.accel_y;
  assign fld[2] = in_data.accel_z;
  assign fld[3] = in_data.gyro_x;
  assign fld[4] = in_data.gyro_y;
  assign fld[5] = in_data.gyro_z;
  assign fld[6] = in_data.altitude;

  // accept while idle; a waiting result only blocks once a second is done
  assign in_ready = !busy_r && !pend_r;
  assign accept = in_valid && in_ready;
  assign ctl = '{start: accept, q: q_r, r: r_r};

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    if (g < NUM_FIELDS) begin : g_z
      assign zin[g] = fld[g];
    end else begin : g_nz
      assign zin[g] = '0;
    end
    dkbc_lane u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .z(zin[g]),
      .est(est[g]), .var_p(vp[g]), .done(done[g])
    );
  end

  dkbc_merge #(.CHANNELS(CHANNELS)) u_merge (
    .est(est), .var_p(vp), .thresh(th_r), .armed_in(armed_r), .item(merged)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= ONE_Q24;
      r_r <= ONE_Q24;
      th_r <= THRESH_RESET;
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      armed_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROCESS_NOISE: q_r <= cfg_wdata;
          REG_MEAS_NOISE:    r_r <= cfg_wdata;
          REG_THRESHOLD:     th_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) busy_r <= 1'b1;
      // hold a finished result in the lanes until the output register frees
      if (done[0]) begin
        busy_r <= 1'b0;
        pend_r <= 1'b1;
      end
      if (pend_r && (!out_valid_r || out_ready)) begin
        out_r <= merged;
        armed_r <= merged.armed;
        out_valid_r <= 1'b1;
        pend_r <= 1'b0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the diagonal Kalman bias calibrator: a directed
// table of samples, then random samples under several noise settings, with
// every result compared against a built-in scalar filter per channel.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dkbc_pkg::*;

  localparam int LANES = 7;
  localparam int RANDOM_ITEMS = 1950;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  diagonal_kalman_bias_calibrator_core #(.CHANNELS(LANES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Filter state mirrored from the block's point of view.
  logic [31:0] q_noise, r_noise, var_limit;
  logic signed [31:0] est_x [LANES];
  logic [31:0] est_p [LANES];
  logic armed_seen;

  out_item_t calib_q[$];
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic reset_filter();
    q_noise = 32'd16777216;
    r_noise = 32'd16777216;
    var_limit = 32'd1595949;
    for (int i = 0; i < LANES; i++) begin
      est_x[i] = '0;
      est_p[i] = 32'd16777216;
    end
    armed_seen = 1'b0;
  endtask

  // Run one scalar update per lane, then form the expected output item.
  function automatic out_item_t filter_sample(input in_item_t s);
    logic signed [31:0] z [LANES];
    logic [63:0] p, sum, k, mag, m;
    logic signed [63:0] d;
    logic conv;
    out_item_t o;
    z[0] = s.accel_x; z[1] = s.accel_y; z[2] = s.accel_z;
    z[3] = s.gyro_x; z[4] = s.gyro_y; z[5] = s.gyro_z; z[6] = s.altitude;
    conv = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      p = {32'd0, est_p[i]} + {32'd0, q_noise};
      if (p > 64'hFFFFFFFF) p = 64'hFFFFFFFF;
      sum = p + {32'd0, r_noise};
      k = (sum == 0) ? 64'd0 : ((p << 24) / sum);
      if (k > 64'd16777216) k = 64'd16777216;
      est_p[i] = 32'((p * (64'd16777216 - k)) >> 24);
      d = 64'(signed'(z[i])) - 64'(signed'(est_x[i]));
      mag = (d < 0) ? 64'(-d) : 64'(d);
      m = (mag * k + 64'd8388608) >> 24;
      est_x[i] = clamp32(64'(signed'(est_x[i])) + ((d < 0) ? -$signed(m) : $signed(m)));
      if (est_p[i] > var_limit) conv = 1'b0;
    end
    if (conv) armed_seen = 1'b1;
    o.accel_x_cal = est_x[0];
    o.accel_y_cal = est_x[1];
    o.accel_z_cal = clamp32(64'(signed'(est_x[2])) + 64'sd642908);
    o.gyro_x_cal = est_x[3];
    o.gyro_y_cal = est_x[4];
    o.gyro_z_cal = est_x[5];
    o.altitude_cal = est_x[6];
    o.converged = conv;
    o.armed = armed_seen;
    return o;
  endfunction

  // Mostly short gaps, now and then a long one, sometimes a run with none.
  function automatic int gap_len(input bit no_gaps);
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  bit tight_phase = 1'b0;

  // Result side: random stalls, compare each item with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (calib_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        out_item_t e;
        e = calib_q.pop_front();
        if (out_data !== e) begin
          errors++;
          $display("%0t: result mismatch expected %h actual %h", $time, e, out_data);
          if (out_data.accel_z_cal !== e.accel_z_cal)
            $display("%0t: accel_z_cal expected %0d actual %0d", $time,
                     e.accel_z_cal, out_data.accel_z_cal);
          if (out_data.converged !== e.converged || out_data.armed !== e.armed)
            $display("%0t: flags expected %b%b actual %b%b", $time,
                     e.converged, e.armed, out_data.converged, out_data.armed);
        end
      end
    end
  end

  int out_hold = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      // Pick the stall that follows this item.
      out_hold <= gap_len(tight_phase);
      out_ready <= (gap_len(tight_phase) == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one sample, hold it until accepted, and queue its expectation.
  // Valid drops only for a gap, so back-to-back items keep it high.
  task automatic send_sample(input in_item_t s, input bit no_gaps);
    int g;
    g = gap_len(no_gaps);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calib_q.push_back(filter_sample(s));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PROCESS_NOISE: q_noise = val;
      REG_MEAS_NOISE: r_noise = val;
      REG_THRESHOLD: var_limit = val;
      default: ;
    endcase
  endtask

  // Drop valid, hold until every result is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (calib_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      default: return $urandom();
    endcase
  endfunction

  // Samples near a drifting bias keep the filters in their useful range.
  function automatic in_item_t random_sample(input logic signed [31:0] bias);
    in_item_t s;
    logic [31:0] w [LANES];
    for (int i = 0; i < LANES; i++) begin
      if ($urandom_range(0, 9) == 0) w[i] = edge_word();
      else w[i] = bias + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
    end
    s = {w[0], w[1], w[2], w[3], w[4], w[5], w[6]};
    return s;
  endfunction

  typedef struct {
    in_item_t smp;
    bit has_exp;
    out_item_t expv;
  } stim_row_t;

  stim_row_t dir_table[$];

  initial begin
    in_item_t s;
    stim_row_t row;
    logic [31:0] qv, rv, tv;
    reset_filter();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows. Zero input after reset leaves every estimate at zero
    // with gravity on z; variance 2/3 is not converged.
    row.smp = '0; row.has_exp = 1'b1;
    row.expv = '{0, 0, 32'sd642908, 0, 0, 0, 0, 1'b0, 1'b0};
    dir_table.push_back(row);
    row.has_exp = 1'b0;
    row.smp = {7{32'h7FFFFFFF}}; dir_table.push_back(row);
    row.smp = {7{32'h7FFFFFFF}}; dir_table.push_back(row);
    row.smp = {7{32'h80000000}}; dir_table.push_back(row);
    row.smp = {7{32'h80000000}}; dir_table.push_back(row);
    row.smp = {32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
               32'h7FFFFFFF, 32'h80000000, 32'h00000001};
    dir_table.push_back(row);
    row.smp = {7{32'hFFFFFFFF}}; dir_table.push_back(row);
    row.smp = {7{32'hAAAAAAAA}}; dir_table.push_back(row);
    row.smp = {7{32'h55555555}}; dir_table.push_back(row);
    for (int i = 0; i < 8; i++) begin
      row.smp = {7{32'h00010000}}; dir_table.push_back(row);
    end
    foreach (dir_table[i]) begin
      s = dir_table[i].smp;
      send_sample(s, 1'b0);
      if (dir_table[i].has_exp && calib_q[$] !== dir_table[i].expv) begin
        errors++;
        $display("%0t: table row %0d expected %h computed %h", $time, i,
                 dir_table[i].expv, calib_q[$]);
      end
    end
    drain();

    // Zero denominator: q = r = 0 with variances driven to zero first.
    write_reg(REG_PROCESS_NOISE, 32'd0);
    write_reg(REG_MEAS_NOISE, 32'd0);
    for (int i = 0; i < 4; i++) send_sample({7{32'h12345678}}, 1'b0);
    drain();
    // Variance overflow: largest q and r, also the extremes of the threshold.
    write_reg(REG_PROCESS_NOISE, 32'hFFFFFFFF);
    write_reg(REG_MEAS_NOISE, 32'hFFFFFFFF);
    write_reg(REG_THRESHOLD, 32'hFFFFFFFF);
    for (int i = 0; i < 3; i++) send_sample(random_sample($urandom()), 1'b0);
    drain();
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_MEAS_NOISE, 32'd0);
    send_sample(random_sample(32'sh00050000), 1'b0);
    drain();

    // Random phases, cycling through five kinds of noise setting.
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 5)
        0: begin qv = 32'd16777216; rv = 32'd16777216; tv = 32'd1595949; end
        1: begin qv = $urandom_range(0, 32'h00040000); rv = $urandom_range(1, 32'h04000000);
                 tv = $urandom_range(0, 32'h01000000); end
        2: begin qv = $urandom(); rv = $urandom(); tv = $urandom(); end
        3: begin qv = 32'd0; rv = $urandom_range(0, 32'h00100000); tv = 32'd0; end
        default: begin qv = $urandom_range(0, 32'h100); rv = 32'hFFFFFFFF;
                       tv = $urandom_range(32'h00100000, 32'h02000000); end
      endcase
      write_reg(REG_PROCESS_NOISE, qv);
      write_reg(REG_MEAS_NOISE, rv);
      write_reg(REG_THRESHOLD, tv);
      tight_phase = (ph % 4 == 3);
      s = '0;
      for (int n = 0; n < RANDOM_ITEMS / 13; n++)
        send_sample(random_sample($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh007FFFFF),
                    tight_phase);
      drain();
    end

    $display("covered %0d results over directed rows and 13 random noise settings",
             results_seen);
    $display("extremes, zero denominator, variance saturation and threshold ends included");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
